// ===== hdl/tbgc_pkg.sv =====
package tbgc_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_DOUBLE_CLICK = 2'd0;
  localparam logic [1:0] REG_COMBO_WINDOW = 2'd1;
  localparam logic [1:0] REG_COMBO_HOLD   = 2'd2;

  // Register reset values
  localparam logic [15:0] DOUBLE_CLICK_RST = 16'd350;
  localparam logic [15:0] COMBO_WINDOW_RST = 16'd200;
  localparam logic [15:0] COMBO_HOLD_RST   = 16'd2000;

  localparam int CFG_ADDR_BITS = 4;
  localparam int CFG_DATA_BITS = 32;
  localparam int ACTION_BITS   = 3;

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_NONE         = 3'd0,
    ACT_STOP_SINGLE  = 3'd1,
    ACT_START_SINGLE = 3'd2,
    ACT_START_DOUBLE = 3'd3,
    ACT_COMBO        = 3'd4
  } action_t;

  typedef struct packed {
    logic [15:0] double_click_ms;
    logic [15:0] combo_window_ms;
    logic [15:0] combo_hold_ms;
  } cfg_t;

endpackage

// ===== hdl/tbgc_in_if.sv =====
interface tbgc_in_if;
  logic valid;
  logic ready;
  logic start_press;
  logic start_release;
  logic stop_press;
  logic stop_release;

  modport source (
    output valid, start_press, start_release, stop_press, stop_release,
    input  ready
  );
  modport sink (
    input  valid, start_press, start_release, stop_press, stop_release,
    output ready
  );
endinterface

// ===== hdl/tbgc_out_if.sv =====
interface tbgc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;

  modport source (
    output valid, action,
    input  ready
  );
  modport sink (
    input  valid, action,
    output ready
  );
endinterface

// ===== hdl/two_button_gesture_classifier_core.sv =====
// Channel  Dir  Handshake     Word
// in_if    in   valid/ready   start_press, start_release, stop_press, stop_release
// out_if   out  valid/ready   action[2:0]
// cfg_*    in   APB write/rd  double_click_ms, combo_window_ms, combo_hold_ms
//
// One word per cycle sustained while out_if is ready; a result word is offered after
// its tick word has passed the input register and then the result register.
// The classifier state is updated when a word moves from the input register to the
// result register, so the result register and state always advance together.
// Reset (rst_n low, synchronous) clears tick time, flags, stamps and both valids,
// and loads the register defaults. A stall on out_if backs up one stage at a time.
module two_button_gesture_classifier_core
  import tbgc_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  tbgc_in_if.sink                  in_if,
  tbgc_out_if.source               out_if,
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [CFG_DATA_BITS-1:0] cfg_pwdata,
  output logic [CFG_DATA_BITS-1:0] cfg_prdata,
  output logic                     cfg_pready
);

  cfg_t    cfg;
  action_t action_nxt;

  logic       s1_valid_r;
  logic       s1_start_press_r, s1_start_release_r;
  logic       s1_stop_press_r, s1_stop_release_r;
  logic       s1_adv;
  logic       out_valid_r;
  logic [2:0] out_action_r;

  tbgc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Pipeline control
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || s1_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      s1_start_press_r   <= in_if.start_press;
      s1_start_release_r <= in_if.start_release;
      s1_stop_press_r    <= in_if.stop_press;
      s1_stop_release_r  <= in_if.stop_release;
    end
  end

  tbgc_classify #(
    .TIME_BITS (TIME_BITS)
  ) u_classify (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_en       (s1_adv),
    .start_press   (s1_start_press_r),
    .start_release (s1_start_release_r),
    .stop_press    (s1_stop_press_r),
    .stop_release  (s1_stop_release_r),
    .cfg           (cfg),
    .action        (action_nxt)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_action_r <= action_nxt;
    end
  end

  assign out_if.valid  = out_valid_r;
  assign out_if.action = out_action_r;

`ifndef ASSERT_OFF
  a_no_overrun : assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready && s1_valid_r) |-> s1_adv)
    else $error("input register overwritten before it moved on");

  a_action_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_action_r <= ACT_COMBO))
    else $error("result word carries an undefined action");

  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_if.ready) |=> (out_valid_r && $stable(out_action_r)))
    else $error("result word changed while stalled");
`endif

endmodule

// ===== hdl/tbgc_cfg_regs.sv =====
module tbgc_cfg_regs
  import tbgc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready,
  output cfg_t                     cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg     = cfg_r;

  // Register writes; unmapped index is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.double_click_ms <= DOUBLE_CLICK_RST;
      cfg_r.combo_window_ms <= COMBO_WINDOW_RST;
      cfg_r.combo_hold_ms   <= COMBO_HOLD_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_DOUBLE_CLICK: cfg_r.double_click_ms <= pwdata[15:0];
        REG_COMBO_WINDOW: cfg_r.combo_window_ms <= pwdata[15:0];
        REG_COMBO_HOLD:   cfg_r.combo_hold_ms   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      REG_DOUBLE_CLICK: prdata = {16'd0, cfg_r.double_click_ms};
      REG_COMBO_WINDOW: prdata = {16'd0, cfg_r.combo_window_ms};
      REG_COMBO_HOLD:   prdata = {16'd0, cfg_r.combo_hold_ms};
      default:          prdata = '0;
    endcase
  end

endmodule

// ===== hdl/tbgc_classify.sv =====
module tbgc_classify
  import tbgc_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step_en,
  input  logic    start_press,
  input  logic    start_release,
  input  logic    stop_press,
  input  logic    stop_release,
  input  cfg_t    cfg,
  output action_t action
);

  localparam int PAD = TIME_BITS - 16;

  logic [TIME_BITS-1:0] tick_r, tick_nxt;
  logic                 start_wait_r, start_wait_nxt;
  logic                 stop_wait_r, stop_wait_nxt;
  logic [TIME_BITS-1:0] start_stamp_r, start_stamp_nxt;
  logic [TIME_BITS-1:0] stop_stamp_r, stop_stamp_nxt;
  logic                 armed_r, armed_nxt;
  logic [TIME_BITS-1:0] combo_stamp_r, combo_stamp_nxt;

  logic [TIME_BITS-1:0] dbl_ms, win_ms, hold_ms;
  logic [TIME_BITS-1:0] d_ss_ts, d_ts_ss, press_gap;
  logic [TIME_BITS-1:0] el_combo, el_stop, el_start, el_prev;
  logic                 sw1, tw1, arm_new, armed1;

  assign dbl_ms  = {{PAD{1'b0}}, cfg.double_click_ms};
  assign win_ms  = {{PAD{1'b0}}, cfg.combo_window_ms};
  assign hold_ms = {{PAD{1'b0}}, cfg.combo_hold_ms};

  // Presses land first
  assign sw1             = start_wait_r | start_press;
  assign tw1             = stop_wait_r | stop_press;
  assign start_stamp_nxt = start_press ? tick_r : start_stamp_r;
  assign stop_stamp_nxt  = stop_press ? tick_r : stop_stamp_r;

  // Wrapped press-time distance, shorter way round
  assign d_ss_ts   = start_stamp_nxt - stop_stamp_nxt;
  assign d_ts_ss   = stop_stamp_nxt - start_stamp_nxt;
  assign press_gap = (d_ss_ts < d_ts_ss) ? d_ss_ts : d_ts_ss;

  assign arm_new         = !armed_r && sw1 && tw1 && (press_gap <= win_ms);
  assign armed1          = armed_r | arm_new;
  assign combo_stamp_nxt = arm_new ? tick_r : combo_stamp_r;

  assign el_combo = tick_r - combo_stamp_nxt;
  assign el_stop  = tick_r - stop_stamp_nxt;
  assign el_start = tick_r - start_stamp_nxt;
  assign el_prev  = tick_r - start_stamp_r;
  assign tick_nxt = tick_r + {{(TIME_BITS-1){1'b0}}, 1'b1};

  // Classification
  always_comb begin
    action         = ACT_NONE;
    armed_nxt      = armed1;
    start_wait_nxt = sw1;
    stop_wait_nxt  = tw1;
    if (armed1) begin
      if (start_release || stop_release) begin
        armed_nxt      = 1'b0;
        start_wait_nxt = 1'b0;
        stop_wait_nxt  = 1'b0;
      end else if (el_combo >= hold_ms) begin
        action         = ACT_COMBO;
        armed_nxt      = 1'b0;
        start_wait_nxt = 1'b0;
        stop_wait_nxt  = 1'b0;
      end
    end else begin
      if (tw1 && !sw1 && (el_stop > win_ms)) begin
        action        = ACT_STOP_SINGLE;
        stop_wait_nxt = 1'b0;
      end
      if (sw1) begin
        if (start_press && start_wait_r && (el_prev <= dbl_ms)) begin
          action         = ACT_START_DOUBLE;
          start_wait_nxt = 1'b0;
        end else if (el_start > dbl_ms) begin
          action         = ACT_START_SINGLE;
          start_wait_nxt = 1'b0;
        end
      end
    end
  end

  // State update, one tick per word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r        <= '0;
      start_wait_r  <= 1'b0;
      stop_wait_r   <= 1'b0;
      start_stamp_r <= '0;
      stop_stamp_r  <= '0;
      armed_r       <= 1'b0;
      combo_stamp_r <= '0;
    end else if (step_en) begin
      tick_r        <= tick_nxt;
      start_wait_r  <= start_wait_nxt;
      stop_wait_r   <= stop_wait_nxt;
      start_stamp_r <= start_stamp_nxt;
      stop_stamp_r  <= stop_stamp_nxt;
      armed_r       <= armed_nxt;
      combo_stamp_r <= combo_stamp_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_armed_needs_both : assert property (@(posedge clk) disable iff (!rst_n)
    armed_r |-> (start_wait_r && stop_wait_r))
    else $error("combo armed without both presses waiting");

  a_combo_disarms : assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && action == ACT_COMBO) |=> (!armed_r && !start_wait_r && !stop_wait_r))
    else $error("combo fired but state not cleared");

  a_tick_advance : assert property (@(posedge clk) disable iff (!rst_n)
    step_en |=> (tick_r == $past(tick_nxt)))
    else $error("tick did not advance by one");
`endif

endmodule

// ===== verif/tbgc_checker.sv =====
// Watches both channels and the register port, predicts one action per tick
// word and compares it with what the block returns.
module tbgc_checker
  import tbgc_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  tbgc_in_if                       in_ch,
  tbgc_out_if                      out_ch,
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [CFG_DATA_BITS-1:0] cfg_pwdata,
  input  logic                     cfg_pready,
  output int                       fail_count,
  output int                       words_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [TIME_BITS-1:0] stamp_t;

  // Shadow of the timing registers and of the classifier state
  cfg_t    timing;
  stamp_t  tick_now;
  stamp_t  start_at;
  stamp_t  stop_at;
  stamp_t  combo_at;
  logic    start_wait;
  logic    stop_wait;
  logic    combo_on;

  action_t pending_actions[$];
  action_t want;
  int      mismatches = 0;

  // Wrapped time since a stamp
  function automatic stamp_t since(input stamp_t now_t, input stamp_t then_t);
    return now_t - then_t;
  endfunction

  // Shorter of the two wrapped distances between two stamps
  function automatic stamp_t spread(input stamp_t a, input stamp_t b);
    stamp_t d1;
    stamp_t d2;
    d1 = a - b;
    d2 = b - a;
    return (d1 < d2) ? d1 : d2;
  endfunction

  // Advance the shadow state by one tick and return the action it yields
  function automatic action_t classify_tick(input logic s_press, input logic s_rel,
                                            input logic t_press, input logic t_rel);
    action_t act;
    logic    had_start;
    stamp_t  prev_start;
    act        = ACT_NONE;
    had_start  = start_wait;
    prev_start = start_at;

    // presses are taken before releases
    if (s_press) begin
      start_wait = 1'b1;
      start_at   = tick_now;
    end
    if (t_press) begin
      stop_wait = 1'b1;
      stop_at   = tick_now;
    end

    // both pressed close together: arm the combo
    if (!combo_on && start_wait && stop_wait &&
        spread(start_at, stop_at) <= stamp_t'(timing.combo_window_ms)) begin
      combo_on = 1'b1;
      combo_at = tick_now;
    end

    if (combo_on) begin
      // any release cancels, otherwise fire once the hold time is reached
      if (s_rel || t_rel) begin
        combo_on   = 1'b0;
        start_wait = 1'b0;
        stop_wait  = 1'b0;
      end else if (since(tick_now, combo_at) >= stamp_t'(timing.combo_hold_ms)) begin
        act        = ACT_COMBO;
        combo_on   = 1'b0;
        start_wait = 1'b0;
        stop_wait  = 1'b0;
      end
    end else begin
      if (stop_wait && !start_wait &&
          since(tick_now, stop_at) > stamp_t'(timing.combo_window_ms)) begin
        act       = ACT_STOP_SINGLE;
        stop_wait = 1'b0;
      end
      if (start_wait) begin
        // gap measured from the earlier press, not the one just stamped
        if (s_press && had_start &&
            since(tick_now, prev_start) <= stamp_t'(timing.double_click_ms)) begin
          act        = ACT_START_DOUBLE;
          start_wait = 1'b0;
        end else if (since(tick_now, start_at) > stamp_t'(timing.double_click_ms)) begin
          act        = ACT_START_SINGLE;
          start_wait = 1'b0;
        end
      end
    end

    tick_now = tick_now + 1'b1;
    return act;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      timing.double_click_ms = DOUBLE_CLICK_RST;
      timing.combo_window_ms = COMBO_WINDOW_RST;
      timing.combo_hold_ms   = COMBO_HOLD_RST;
      tick_now   = '0;
      start_at   = '0;
      stop_at    = '0;
      combo_at   = '0;
      start_wait = 1'b0;
      stop_wait  = 1'b0;
      combo_on   = 1'b0;
      pending_actions.delete();
    end else begin
      // result word: compare with the oldest prediction
      if (out_ch.valid && out_ch.ready) begin
        if (pending_actions.size() == 0) begin
          $display("%0t: unexpected action word: expected none, actual %0d",
                   $time, out_ch.action);
          mismatches++;
        end else begin
          want = pending_actions.pop_front();
          if (out_ch.action !== want) begin
            $display("%0t: action mismatch: expected %0d (%s), actual %0d",
                     $time, want, want.name(), out_ch.action);
            mismatches++;
          end
        end
      end

      // tick word: predict its action
      if (in_ch.valid && in_ch.ready)
        pending_actions.push_back(classify_tick(in_ch.start_press, in_ch.start_release,
                                                in_ch.stop_press, in_ch.stop_release));

      // register write; only the low 16 bits are kept
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          REG_DOUBLE_CLICK: timing.double_click_ms = cfg_pwdata[15:0];
          REG_COMBO_WINDOW: timing.combo_window_ms = cfg_pwdata[15:0];
          REG_COMBO_HOLD:   timing.combo_hold_ms   = cfg_pwdata[15:0];
          default: ;
        endcase
      end
    end
    words_pending <= pending_actions.size();
    fail_count    <= mismatches;
  end

endmodule

// ===== verif/tb_top.sv =====
module tb_top
  import tbgc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         TIME_BITS      = 32;
  localparam int         STALL_LIMIT    = 3000;
  localparam int         SPAN_CAP       = 40;
  localparam logic [1:0] REG_UNMAPPED   = 2'd3;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_psel;
  logic                     cfg_penable;
  logic                     cfg_pwrite;
  logic [CFG_ADDR_BITS-1:0] cfg_paddr;
  logic [CFG_DATA_BITS-1:0] cfg_pwdata;
  logic [CFG_DATA_BITS-1:0] cfg_prdata;
  logic                     cfg_pready;

  int   fail_count;
  int   words_pending;
  int   words_sent = 0;
  int   quiet_cycles = 0;
  int   stall_left = 0;
  bit   idle_en = 1'b1;

  // timing in force, used only to shape gesture lengths
  int   cur_dbl  = DOUBLE_CLICK_RST;
  int   cur_win  = COMBO_WINDOW_RST;
  int   cur_hold = COMBO_HOLD_RST;

  tbgc_in_if  in_ch ();
  tbgc_out_if out_ch ();

  two_button_gesture_classifier_core #(
    .TIME_BITS (TIME_BITS)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  tbgc_checker #(
    .TIME_BITS (TIME_BITS)
  ) i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_pready    (cfg_pready),
    .fail_count    (fail_count),
    .words_pending (words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side back-pressure in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      out_ch.ready  <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left    <= $urandom_range(0, 7);
      out_ch.ready  <= 1'b0;
    end else begin
      out_ch.ready  <= 1'b1;
    end
  end

  // Watchdog on cycles with no word or register access moving
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_psel && cfg_penable && cfg_pready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int capped(input int span);
    return (span > SPAN_CAP) ? SPAN_CAP : span;
  endfunction

  // One tick word, with an optional random gap in front
  task automatic send_tick(input bit s_press, input bit s_rel,
                           input bit t_press, input bit t_rel);
    int gap;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 8);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.start_press   <= s_press;
    in_ch.start_release <= s_rel;
    in_ch.stop_press    <= t_press;
    in_ch.stop_release  <= t_rel;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
  endtask

  task automatic idle_ticks(input int n);
    repeat (n) send_tick(1'b0, 1'b0, 1'b0, 1'b0);
  endtask

  // Two-phase register write
  task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_BITS-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Upper halves carry junk that the block must drop
  task automatic set_timing(input int dbl, input int win, input int hold);
    write_reg(REG_DOUBLE_CLICK, {16'($urandom), 16'(dbl)});
    write_reg(REG_COMBO_WINDOW, {16'($urandom), 16'(win)});
    write_reg(REG_COMBO_HOLD,   {16'($urandom), 16'(hold)});
    cur_dbl  = dbl;
    cur_win  = win;
    cur_hold = hold;
  endtask

  // Drain every outstanding word before touching registers
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One random gesture: mostly well-formed, some noise
  task automatic play_gesture();
    int  kind;
    int  d;
    bit  first_start;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1: begin
        // start click
        send_tick(1'b1, 1'b0, 1'b0, 1'b0);
        idle_ticks($urandom_range(0, capped(cur_dbl)));
        send_tick(1'b0, 1'b1, 1'b0, 1'b0);
        idle_ticks($urandom_range(0, capped(cur_dbl + 2)));
      end
      2: begin
        // double click, second press sometimes released in the same tick
        send_tick(1'b1, 1'b0, 1'b0, 1'b0);
        idle_ticks($urandom_range(0, capped(cur_dbl / 2)));
        send_tick(1'b0, 1'b1, 1'b0, 1'b0);
        idle_ticks($urandom_range(0, capped(cur_dbl / 2 + 1)));
        send_tick(1'b1, 1'($urandom_range(0, 1)), 1'b0, 1'b0);
        send_tick(1'b0, 1'b1, 1'b0, 1'b0);
        idle_ticks($urandom_range(0, capped(cur_dbl + 2)));
      end
      3: begin
        // stop click
        send_tick(1'b0, 1'b0, 1'b1, 1'b0);
        idle_ticks($urandom_range(0, capped(cur_win)));
        send_tick(1'b0, 1'b0, 1'b0, 1'b1);
        idle_ticks($urandom_range(0, capped(cur_win + 2)));
      end
      4, 5, 6: begin
        // two-button hold, released together or one after the other
        first_start = $urandom_range(0, 1);
        d = $urandom_range(0, capped(cur_win + 1));
        if (d == 0) begin
          send_tick(1'b1, 1'b0, 1'b1, 1'b0);
        end else begin
          send_tick(first_start, 1'b0, !first_start, 1'b0);
          idle_ticks(d - 1);
          send_tick(!first_start, 1'b0, first_start, 1'b0);
        end
        idle_ticks($urandom_range(0, capped(cur_hold + 3)));
        case ($urandom_range(0, 2))
          0: send_tick(1'b0, 1'b1, 1'b0, 1'b1);
          1: begin
            send_tick(1'b0, 1'b1, 1'b0, 1'b0);
            send_tick(1'b0, 1'b0, 1'b0, 1'b1);
          end
          default: begin
            send_tick(1'b0, 1'b0, 1'b0, 1'b1);
            send_tick(1'b0, 1'b1, 1'b0, 1'b0);
          end
        endcase
        idle_ticks($urandom_range(0, 4));
      end
      7: begin
        // raw noise on the start and stop press and release bits
        repeat ($urandom_range(1, 6)) begin
          d = $urandom_range(0, 15);
          send_tick(d[0], d[1], d[2], d[3]);
        end
      end
      8: idle_ticks($urandom_range(1, capped(cur_dbl + cur_win + 5)));
      default: begin
        // stop press overtaken by a start press
        send_tick(1'b0, 1'b0, 1'b1, 1'b0);
        idle_ticks($urandom_range(0, capped(cur_win + 3)));
        send_tick(1'b1, 1'b0, 1'b0, 1'b0);
        idle_ticks($urandom_range(0, capped(cur_dbl)));
        send_tick(1'b0, 1'b1, 1'b0, 1'b1);
        idle_ticks($urandom_range(0, capped(cur_dbl + 2)));
      end
    endcase
  endtask

  task automatic run_phase(input int n_words);
    int first;
    first = words_sent;
    while (words_sent - first < n_words) play_gesture();
  endtask

  // Short fixed sequence under timing 3 / 2 / 4
  task automatic directed_ticks();
    // start click, then single after the double-click gap
    send_tick(1'b1, 1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b0, 1'b0);
    idle_ticks(3);
    // double click
    send_tick(1'b1, 1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b0, 1'b0);
    // stop click
    send_tick(1'b0, 1'b0, 1'b1, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0, 1'b1);
    idle_ticks(2);
    // combo held until it fires
    send_tick(1'b1, 1'b0, 1'b1, 1'b0);
    idle_ticks(4);
    send_tick(1'b0, 1'b1, 1'b0, 1'b1);
    // combo cancelled by one release
    send_tick(1'b0, 1'b0, 1'b1, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0, 1'b1);
    // press and release of both in one tick
    send_tick(1'b1, 1'b1, 1'b1, 1'b1);
    // release with nothing armed
    send_tick(1'b0, 1'b1, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0, 1'b1);
  endtask

  initial begin
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.start_press   <= 1'b0;
    in_ch.start_release <= 1'b0;
    in_ch.stop_press    <= 1'b0;
    in_ch.stop_release  <= 1'b0;
    cfg_psel            <= 1'b0;
    cfg_penable         <= 1'b0;
    cfg_pwrite          <= 1'b0;
    cfg_paddr           <= '0;
    cfg_pwdata          <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset timing first
    run_phase(120);

    settle();
    set_timing(3, 2, 4);
    directed_ticks();
    run_phase(100);

    // extremes
    settle();
    set_timing(0, 0, 0);
    run_phase(140);
    settle();
    set_timing(65535, 65535, 65535);
    run_phase(140);

    // unmapped register must leave the timing alone
    settle();
    write_reg(REG_UNMAPPED, $urandom);
    set_timing($urandom_range(1, 12), $urandom_range(0, 6), $urandom_range(0, 15));
    write_reg(REG_UNMAPPED, $urandom);
    run_phase(140);

    repeat (6) begin
      settle();
      set_timing($urandom_range(1, 30), $urandom_range(0, 15), $urandom_range(0, 40));
      run_phase(140);
    end

    // last stretch at full rate
    settle();
    set_timing($urandom_range(1, 30), $urandom_range(0, 15), $urandom_range(0, 40));
    idle_en = 1'b0;
    run_phase(150);

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== two_button_gesture_classifier_core.f =====
hdl/tbgc_pkg.sv
hdl/tbgc_in_if.sv
hdl/tbgc_out_if.sv
hdl/tbgc_cfg_regs.sv
hdl/tbgc_classify.sv
hdl/two_button_gesture_classifier_core.sv
verif/tbgc_checker.sv
verif/tb_top.sv
